// ===== rtl/mfek_pkg.sv =====
// Shared types and constants for the max-flow block.
package mfek_pkg;

  localparam int NumVert  = 64;
  localparam int VertW    = 6;
  localparam int CapW     = 31;
  localparam int CellW    = 32;
  localparam int FlowW    = 37;
  localparam int CellAddrW = 2 * VertW;

  localparam logic [CapW-1:0] CapMax = {CapW{1'b1}};

  // Command codes
  localparam logic OpAdd     = 1'b0;
  localparam logic OpCompute = 1'b1;

  // Configuration register indexes
  localparam logic CfgSource = 1'b0;
  localparam logic CfgSink   = 1'b1;

  typedef struct packed {
    logic             op;
    logic [VertW-1:0] from_vertex;
    logic [VertW-1:0] to_vertex;
    logic [CapW-1:0]  edge_capacity;
  } cmd_t;

  typedef struct packed {
    logic [FlowW-1:0] max_flow_value;
    logic             capacity_saturated;
  } res_t;

  typedef struct packed {
    logic [VertW-1:0] vertex;
    logic [CapW-1:0]  flow;
  } qent_t;

endpackage

// ===== rtl/mfek_ram.sv =====
// Single-port synchronous RAM with registered read data.
module mfek_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/max_flow_edmonds_karp.sv =====
// Maximum flow engine: edge loader, breadth-first search and augmenting sequencer.
//
// An add command reads one matrix cell, then writes back its saturating sum.
// A compute command runs rounds of breadth-first search over a 64x64 residual
// matrix held in a single-port RAM: each round opens by seeding the queue with
// the source, each dequeued vertex is read from the queue and its row scanned
// (one read per column, then the read pipeline drains), finding the queue empty
// ends the command, and each path edge does a read-modify-write of its forward and
// reverse cells. The result strobe opens a clearing pass of the whole matrix. The
// same clearing pass runs after reset; busy stays high throughout
// and configuration writes are taken at any time. The result is on the result
// ports for one cycle marked by result_valid and cannot be held off.
module max_flow_edmonds_karp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  mfek_pkg::cmd_t               cmd,
  output logic                         result_valid,
  output mfek_pkg::res_t               result,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [mfek_pkg::VertW-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_LD_WR, S_INIT, S_DEQ, S_DEQ_W, S_SCAN,
    S_AUG_PAR, S_AUG_PW, S_F_RD, S_F_WR, S_R_RD, S_R_WR, S_DONE, S_CLEAR
  } state_t;

  state_t state;

  logic [mfek_pkg::VertW-1:0]      src_v, snk_v;
  logic [mfek_pkg::VertW-1:0]      cur_v, prev_v, pend_nx;
  logic [mfek_pkg::CapW-1:0]       cur_fl, bneck, ld_c;
  logic [mfek_pkg::VertW-1:0]      ld_u, ld_v;
  logic [mfek_pkg::FlowW-1:0]      sum;
  logic                            sat;
  logic [mfek_pkg::VertW:0]        q_head, q_tail, scan_nx;
  logic                            pend_valid;
  logic [mfek_pkg::NumVert-1:0]    visited;
  logic [mfek_pkg::CellAddrW-1:0]  clr_addr;

  // Memory ports
  logic                            m_we;
  logic [mfek_pkg::CellAddrW-1:0]  m_addr;
  logic [mfek_pkg::CellW-1:0]      m_wdata, m_rdata;
  logic                            p_we;
  logic [mfek_pkg::VertW-1:0]      p_addr, p_rdata;
  logic                            q_we;
  logic [mfek_pkg::VertW-1:0]      q_addr;
  mfek_pkg::qent_t                 q_wdata, q_rdata;

  // Datapath
  logic [mfek_pkg::CellW:0]        ld_sum;
  logic                            ld_over;
  logic                            hit;
  logic [mfek_pkg::CapW-1:0]       nf;
  logic                            q_room;

  mfek_ram #(.Width(mfek_pkg::CellW), .Depth(mfek_pkg::NumVert * mfek_pkg::NumVert)) u_matrix (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
  );

  mfek_ram #(.Width(mfek_pkg::VertW), .Depth(mfek_pkg::NumVert)) u_parent (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(cur_v), .rdata(p_rdata)
  );

  mfek_ram #(.Width($bits(mfek_pkg::qent_t)), .Depth(mfek_pkg::NumVert)) u_queue (
    .clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wdata), .rdata(q_rdata)
  );

  assign busy = (state != S_IDLE);

  // Saturating add for edge loads
  assign ld_sum  = {1'b0, m_rdata} + (mfek_pkg::CellW + 1)'(ld_c);
  assign ld_over = ld_sum > (mfek_pkg::CellW + 1)'(mfek_pkg::CapMax);

  // Scan hit and path bottleneck so far
  assign hit = (state == S_SCAN) && pend_valid && !visited[pend_nx] && (m_rdata != '0);
  assign nf  = ({1'b0, cur_fl} < m_rdata) ? cur_fl : m_rdata[mfek_pkg::CapW-1:0];
  assign q_room = q_tail < (mfek_pkg::VertW + 1)'(mfek_pkg::NumVert);

  // Matrix port steering
  always_comb begin
    m_we    = 1'b0;
    m_addr  = {cmd.from_vertex, cmd.to_vertex};
    m_wdata = '0;
    case (state)
      S_LD_WR: begin
        m_we    = 1'b1;
        m_addr  = {ld_u, ld_v};
        m_wdata = ld_over ? mfek_pkg::CellW'(mfek_pkg::CapMax)
                          : ld_sum[mfek_pkg::CellW-1:0];
      end
      S_SCAN:  m_addr = {cur_v, scan_nx[mfek_pkg::VertW-1:0]};
      S_F_RD:  m_addr = {prev_v, cur_v};
      S_F_WR: begin
        m_we    = 1'b1;
        m_addr  = {prev_v, cur_v};
        m_wdata = m_rdata - mfek_pkg::CellW'(bneck);
      end
      S_R_RD:  m_addr = {cur_v, prev_v};
      S_R_WR: begin
        m_we    = 1'b1;
        m_addr  = {cur_v, prev_v};
        m_wdata = m_rdata + mfek_pkg::CellW'(bneck);
      end
      S_CLEAR: begin
        m_we   = 1'b1;
        m_addr = clr_addr;
      end
      default: ;
    endcase
  end

  // Parent and queue port steering
  always_comb begin
    p_we    = hit;
    p_addr  = (state == S_SCAN) ? pend_nx : cur_v;
    q_we    = 1'b0;
    q_addr  = q_head[mfek_pkg::VertW-1:0];
    q_wdata = '{vertex: pend_nx, flow: nf};
    if (state == S_INIT) begin
      q_we    = 1'b1;
      q_addr  = '0;
      q_wdata = '{vertex: src_v, flow: mfek_pkg::CapMax};
    end else if (state == S_SCAN) begin
      q_addr = q_tail[mfek_pkg::VertW-1:0];
      q_we   = hit && (pend_nx != snk_v) && q_room;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      src_v        <= '0;
      snk_v        <= mfek_pkg::VertW'(1);
      sat          <= 1'b0;
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      q_head       <= '0;
      q_tail       <= '0;
      scan_nx      <= '0;
    end else begin
      result_valid <= (state == S_DONE);
      if (cfg_we) begin
        unique case (cfg_index)
          mfek_pkg::CfgSource: src_v <= cfg_data;
          mfek_pkg::CfgSink:   snk_v <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (cmd.op == mfek_pkg::OpAdd) begin
              ld_u  <= cmd.from_vertex;
              ld_v  <= cmd.to_vertex;
              ld_c  <= cmd.edge_capacity;
              state <= S_LD_WR;
            end else begin
              sum   <= '0;
              state <= (src_v == snk_v) ? S_DONE : S_INIT;
            end
          end
        end
        S_LD_WR: begin
          if (ld_over) sat <= 1'b1;
          state <= S_IDLE;
        end
        S_INIT: begin
          visited <= mfek_pkg::NumVert'(1) << src_v;
          q_head  <= '0;
          q_tail  <= (mfek_pkg::VertW + 1)'(1);
          state   <= S_DEQ;
        end
        S_DEQ: begin
          if (q_head == q_tail) begin
            state <= S_DONE;
          end else begin
            q_head <= q_head + 1'b1;
            state  <= S_DEQ_W;
          end
        end
        S_DEQ_W: begin
          cur_v      <= q_rdata.vertex;
          cur_fl     <= q_rdata.flow;
          scan_nx    <= '0;
          pend_valid <= 1'b0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          // Issue the next cell read, judge the previous one
          pend_valid <= scan_nx < (mfek_pkg::VertW + 1)'(mfek_pkg::NumVert);
          pend_nx    <= scan_nx[mfek_pkg::VertW-1:0];
          if (scan_nx < (mfek_pkg::VertW + 1)'(mfek_pkg::NumVert)) scan_nx <= scan_nx + 1'b1;
          if (hit) begin
            visited[pend_nx] <= 1'b1;
            if (pend_nx == snk_v) begin
              bneck <= nf;
              sum   <= sum + mfek_pkg::FlowW'(nf);
              cur_v <= snk_v;
              state <= S_AUG_PAR;
            end else if (q_room) begin
              q_tail <= q_tail + 1'b1;
            end
          end else if (!pend_valid &&
                       scan_nx == (mfek_pkg::VertW + 1)'(mfek_pkg::NumVert)) begin
            state <= S_DEQ;
          end
        end
        S_AUG_PAR: state <= S_AUG_PW;
        S_AUG_PW: begin
          prev_v <= p_rdata;
          state  <= S_F_RD;
        end
        S_F_RD: state <= S_F_WR;
        S_F_WR: state <= S_R_RD;
        S_R_RD: state <= S_R_WR;
        S_R_WR: begin
          cur_v <= prev_v;
          state <= (prev_v == src_v) ? S_INIT : S_AUG_PAR;
        end
        S_DONE: begin
          result   <= '{max_flow_value: sum, capacity_saturated: sat};
          sat      <= 1'b0;
          clr_addr <= '0;
          state    <= S_CLEAR;
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result beat always falls within the clearing pass
  assert property (@(posedge clk) disable iff (rst) result_valid |-> state == S_CLEAR)
    else $error("result beat outside clearing pass");

  // An add command occupies the block for its write cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.op == mfek_pkg::OpAdd) |=> state == S_LD_WR)
    else $error("add command not written");

  // Queue never overruns its storage
  assert property (@(posedge clk) disable iff (rst)
    q_tail <= (mfek_pkg::VertW + 1)'(mfek_pkg::NumVert) && q_head <= q_tail)
    else $error("queue pointers out of range");

endmodule

// ===== dv/tb_max_flow_edmonds_karp.sv =====
// Testbench for the max-flow block: directed table, random graphs, scoreboard.
`timescale 1ns / 100ps

module tb_max_flow_edmonds_karp;

  localparam int CycleLimit = 4_000_000;
  localparam int RandItems  = 750;
  localparam int CapMaxI    = int'(mfek_pkg::CapMax);

  typedef struct {
    mfek_pkg::cmd_t c;
    bit             typed;
    mfek_pkg::res_t r;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  mfek_pkg::cmd_t cmd = '0;
  logic result_valid;
  mfek_pkg::res_t result;
  logic cfg_we = 1'b0;
  logic cfg_index = mfek_pkg::CfgSource;
  logic [mfek_pkg::VertW-1:0] cfg_data = '0;

  max_flow_edmonds_karp dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block: residual matrix, flag and registers
  logic [mfek_pkg::CellW-1:0] resid [mfek_pkg::NumVert][mfek_pkg::NumVert];
  bit                         sat_flag;
  int                         src_reg;
  int                         snk_reg;
  int                         path_parent [mfek_pkg::NumVert];
  bit                         seen [mfek_pkg::NumVert];
  int                         bfs_vert [mfek_pkg::NumVert];
  logic [mfek_pkg::CellW-1:0] bfs_flow [mfek_pkg::NumVert];

  mfek_pkg::res_t flow_q [$];
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  int   burst_left = 1;
  int   sent = 0;

  task automatic report(string what);
    $display("%0t mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  function automatic void clear_matrix();
    foreach (resid[i, j]) resid[i][j] = '0;
    sat_flag = 1'b0;
  endfunction

  // Breadth-first search in ascending neighbor order; returns the bottleneck or 0
  function automatic logic [mfek_pkg::CellW-1:0] path_bottleneck(int s, int d);
    int head, tail, cur;
    logic [mfek_pkg::CellW-1:0] fl, c, nf;
    foreach (seen[i]) seen[i] = 1'b0;
    head = 0;
    tail = 1;
    seen[s] = 1'b1;
    bfs_vert[0] = s;
    bfs_flow[0] = {1'b0, mfek_pkg::CapMax};
    while (head < tail) begin
      cur = bfs_vert[head];
      fl = bfs_flow[head];
      head++;
      for (int nx = 0; nx < mfek_pkg::NumVert; nx++) begin
        c = resid[cur][nx];
        if (!seen[nx] && c != '0) begin
          nf = (fl < c) ? fl : c;
          seen[nx] = 1'b1;
          path_parent[nx] = cur;
          if (nx == d) return nf;
          if (tail < mfek_pkg::NumVert) begin
            bfs_vert[tail] = nx;
            bfs_flow[tail] = nf;
            tail++;
          end
        end
      end
    end
    return '0;
  endfunction

  // Augment along shortest paths until none remain
  function automatic logic [mfek_pkg::FlowW-1:0] augment_all(int s, int d);
    logic [mfek_pkg::FlowW-1:0] sum;
    logic [mfek_pkg::CellW-1:0] b;
    int cur, prev;
    sum = '0;
    if (s == d) return sum;
    b = path_bottleneck(s, d);
    while (b != '0) begin
      sum += mfek_pkg::FlowW'(b);
      cur = d;
      while (cur != s) begin
        prev = path_parent[cur];
        resid[prev][cur] -= b;
        resid[cur][prev] += b;
        cur = prev;
      end
      b = path_bottleneck(s, d);
    end
    return sum;
  endfunction

  // Update the shadow on an accepted beat; return the predicted result
  function automatic mfek_pkg::res_t apply_beat(mfek_pkg::cmd_t c);
    logic [mfek_pkg::CapW:0] s;
    mfek_pkg::res_t r;
    r = '0;
    if (c.op == mfek_pkg::OpAdd) begin
      s = {1'b0, resid[c.from_vertex][c.to_vertex][mfek_pkg::CapW-1:0]}
          + (mfek_pkg::CapW + 1)'(c.edge_capacity);
      if (s > {1'b0, mfek_pkg::CapMax}) begin
        s = {1'b0, mfek_pkg::CapMax};
        sat_flag = 1'b1;
      end
      resid[c.from_vertex][c.to_vertex] = {1'b0, s[mfek_pkg::CapW-1:0]};
    end else begin
      r.max_flow_value = augment_all(src_reg, snk_reg);
      r.capacity_saturated = sat_flag;
      clear_matrix();
    end
    return r;
  endfunction

  // Drive one beat, hold until accepted, then idle per the burst pattern
  task automatic send_beat(mfek_pkg::cmd_t c, bit typed = 1'b0, mfek_pkg::res_t tr = '0);
    mfek_pkg::res_t pr;
    int gap;
    cmd <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pr = apply_beat(c);
    if (c.op == mfek_pkg::OpCompute) flow_q.insert(flow_q.size(), typed ? tr : pr);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Write a register once the block has drained
  task automatic write_reg(logic idx, int val);
    start <= 1'b0;
    @(posedge clk);
    while (flow_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[mfek_pkg::VertW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mfek_pkg::CfgSource) src_reg = val;
    else snk_reg = val;
  endtask

  function automatic mfek_pkg::cmd_t mk(logic op, int u, int v, int cap);
    mfek_pkg::cmd_t c;
    c.op = op;
    c.from_vertex = u[mfek_pkg::VertW-1:0];
    c.to_vertex = v[mfek_pkg::VertW-1:0];
    c.edge_capacity = cap[mfek_pkg::CapW-1:0];
    return c;
  endfunction

  function automatic mfek_pkg::res_t rv(logic [mfek_pkg::FlowW-1:0] f, logic s);
    mfek_pkg::res_t r;
    r.max_flow_value = f;
    r.capacity_saturated = s;
    return r;
  endfunction

  function automatic int rand_cap();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return CapMaxI;
      2: return int'($urandom());
      default: return int'($urandom_range(1, 200));
    endcase
  endfunction

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (flow_q.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        if (result.max_flow_value !== flow_q[0].max_flow_value)
          report($sformatf("flow got %0d exp %0d", result.max_flow_value,
                           flow_q[0].max_flow_value));
        if (result.capacity_saturated !== flow_q[0].capacity_saturated)
          report($sformatf("saturated got %0b exp %0b", result.capacity_saturated,
                           flow_q[0].capacity_saturated));
        void'(flow_q.pop_front());
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_max_flow_edmonds_karp: errors");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    int pool [$];
    int k, n, u, v;

    clear_matrix();
    src_reg = 0;
    snk_reg = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table under reset configuration (source 0, sink 1)
    rows.insert(rows.size(), '{mk(mfek_pkg::OpCompute, 0, 0, 0), 1'b1, rv('0, 1'b0)});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 0, 1, CapMaxI), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 0, 1, 1), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpCompute, 0, 0, 0), 1'b1,
                               rv(37'h7FFFFFFF, 1'b1)});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 0, 63, CapMaxI), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 63, 1, CapMaxI), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 0, 2, CapMaxI), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 2, 1, CapMaxI), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpCompute, 0, 0, 0), 1'b1,
                               rv(37'hFFFFFFFE, 1'b0)});
    // opposite edges at full capacity push the reverse cell past 31 bits
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 0, 1, CapMaxI), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 1, 0, CapMaxI), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpCompute, 0, 0, 0), 1'b1,
                               rv(37'h7FFFFFFF, 1'b0)});
    // self loops and zero capacity carry nothing
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 5, 5, 77), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 0, 0, 9), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 0, 1, 0), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpCompute, 0, 0, 0), 1'b1, rv('0, 1'b0)});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 0, 3, 10), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 3, 1, 4), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 3, 4, 9), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpAdd, 4, 1, 20), 1'b0, '0});
    rows.insert(rows.size(), '{mk(mfek_pkg::OpCompute, 0, 0, 0), 1'b0, '0});
    foreach (rows[i]) send_beat(rows[i].c, rows[i].typed, rows[i].r);

    // Source equal to sink at the top index
    write_reg(mfek_pkg::CfgSource, 63);
    write_reg(mfek_pkg::CfgSink, 63);
    send_beat(mk(mfek_pkg::OpAdd, 63, 62, 5));
    send_beat(mk(mfek_pkg::OpCompute, 0, 0, 0), 1'b1, rv('0, 1'b0));

    // Extremes swapped: source 63, sink 0
    write_reg(mfek_pkg::CfgSink, 0);
    send_beat(mk(mfek_pkg::OpAdd, 63, 0, 1234));
    send_beat(mk(mfek_pkg::OpCompute, 63, 63, CapMaxI), 1'b1, rv(37'd1234, 1'b0));

    // Random graphs on small vertex pools, with the odd full-size graph
    sent = 0;
    while (sent < RandItems) begin
      if ($urandom_range(0, 2) == 0) begin
        write_reg(mfek_pkg::CfgSource,
                  ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0) write_reg(mfek_pkg::CfgSink, src_reg);
        else write_reg(mfek_pkg::CfgSink,
                       ($urandom_range(0, 4) == 0) ? 63 : $urandom_range(0, 63));
      end
      k = ($urandom_range(0, 19) == 0) ? 64 : $urandom_range(2, 9);
      n = (k == 64) ? 30 : $urandom_range(2, 18);
      pool.delete();
      pool.insert(pool.size(), src_reg);
      pool.insert(pool.size(), snk_reg);
      while (pool.size() < k) pool.insert(pool.size(), $urandom_range(0, 63));
      repeat (n) begin
        if ($urandom_range(0, 6) == 0) begin
          u = $urandom_range(0, 63);
          v = $urandom_range(0, 63);
        end else begin
          u = pool[$urandom_range(0, k - 1)];
          v = pool[$urandom_range(0, k - 1)];
        end
        send_beat(mk(mfek_pkg::OpAdd, u, v, rand_cap()));
      end
      send_beat(mk(mfek_pkg::OpCompute, $urandom_range(0, 63), $urandom_range(0, 63),
                   int'($urandom())));
    end

    // Drain, then let the clearing pass finish
    start <= 1'b0;
    @(posedge clk);
    while (flow_q.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_max_flow_edmonds_karp: clean");
    end else begin
      $display("tb_max_flow_edmonds_karp: errors");
    end
    $finish;
  end

endmodule
